// ----- sv/crc8fp_pkg.sv -----
// shared types, constants and crc helper for the crc8 checked frame parser
package crc8fp_pkg;

    localparam int MAX_FRAME = 256;
    localparam int POS_W     = $clog2(MAX_FRAME + 2);
    localparam int CMP_W     = ((POS_W > 9) ? POS_W : 9) + 1;

    localparam int FIELD_FIRST = 3;
    localparam int FIELD_COUNT = 16;
    localparam int FIELD_IDX_W = $clog2(FIELD_COUNT);

    localparam logic [7:0] HDR_BYTE0 = 8'h55;
    localparam logic [7:0] HDR_BYTE1 = 8'hAA;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] LEN_LIMIT = 8'd128;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_HEADER  = 2'd1;
    localparam t_status ST_CRC_BAD = 2'd2;
    localparam t_status ST_LENGTH  = 2'd3;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] yaw_milli;
        logic signed [31:0] left_wheel;
        logic signed [31:0] right_wheel;
        logic signed [31:0] flag_word;
    } t_result;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/crc8fp_in_reg.sv -----
// input register holding one received byte ahead of the frame logic
module crc8fp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ----- sv/crc8fp_core.sv -----
// frame state, byte-wide crc update, field capture and status decision
module crc8fp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_res_valid,
    output crc8fp_pkg::t_result o_res
);
    import crc8fp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_hdr_good;
    logic [7:0]       r_len;
    logic [7:0]       r_crc;
    logic [7:0]       r_rx_crc;
    logic             r_crc_seen;
    logic             r_last_cr;
    logic [7:0]       r_field [FIELD_COUNT];

    logic             n_hdr_good;
    logic [7:0]       n_len;
    logic [7:0]       n_crc;
    logic [7:0]       n_rx_crc;
    logic             n_crc_seen;
    logic [7:0]       n_field [FIELD_COUNT];

    logic [CMP_W-1:0]       p_ext;
    logic [CMP_W-1:0]       crc_pos;
    logic [CMP_W-1:0]       total;
    logic [CMP_W-1:0]       fld_off;
    logic [FIELD_IDX_W-1:0] fld_idx;
    logic                   fld_wr;
    logic                   in_crc;
    logic                   ends;
    t_status                status;

    assign p_ext   = CMP_W'(r_pos);
    assign total   = p_ext + CMP_W'(1);
    assign fld_off = p_ext - CMP_W'(FIELD_FIRST);
    assign fld_idx = fld_off[FIELD_IDX_W-1:0];
    assign fld_wr  = (p_ext >= CMP_W'(FIELD_FIRST))
                  && (p_ext < CMP_W'(FIELD_FIRST + FIELD_COUNT));
    assign ends    = (i_byte == LF_BYTE) && r_last_cr;
    assign o_take  = i_valid && (!ends || i_out_free);
    assign o_res_valid = o_take && ends;

    always_comb begin
        n_hdr_good = r_hdr_good;
        if (p_ext == CMP_W'(0) && i_byte != HDR_BYTE0) begin
            n_hdr_good = 1'b0;
        end
        if (p_ext == CMP_W'(1) && i_byte != HDR_BYTE1) begin
            n_hdr_good = 1'b0;
        end
        n_len = (p_ext == CMP_W'(2)) ? i_byte : r_len;
        crc_pos = CMP_W'(3) + CMP_W'(n_len);
        in_crc = (p_ext < CMP_W'(3)) || (p_ext < crc_pos);
        n_crc = r_crc;
        n_rx_crc = r_rx_crc;
        n_crc_seen = r_crc_seen;
        if (in_crc) begin
            n_crc = crc8_update(r_crc, i_byte);
        end else if (p_ext == crc_pos && !r_crc_seen) begin
            n_rx_crc = i_byte;
            n_crc_seen = 1'b1;
        end
        n_field = r_field;
        if (fld_wr) begin
            n_field[fld_idx] = i_byte;
        end
    end

    always_comb begin
        if (!n_hdr_good) begin
            status = ST_HEADER;
        end else if (total > CMP_W'(MAX_FRAME) || n_len >= LEN_LIMIT
                     || crc_pos >= total || !n_crc_seen) begin
            status = ST_LENGTH;
        end else if (n_crc != n_rx_crc) begin
            status = ST_CRC_BAD;
        end else begin
            status = ST_OK;
        end
        o_res.status = status;
        if (status == ST_OK) begin
            o_res.yaw_milli   = {n_field[3], n_field[2], n_field[1], n_field[0]};
            o_res.left_wheel  = {n_field[7], n_field[6], n_field[5], n_field[4]};
            o_res.right_wheel = {n_field[11], n_field[10], n_field[9], n_field[8]};
            o_res.flag_word   = {n_field[15], n_field[14], n_field[13], n_field[12]};
        end else begin
            o_res.yaw_milli   = '0;
            o_res.left_wheel  = '0;
            o_res.right_wheel = '0;
            o_res.flag_word   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && ends)) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b1;
            r_len      <= '0;
            r_crc      <= '0;
            r_rx_crc   <= '0;
            r_crc_seen <= 1'b0;
            r_last_cr  <= 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_field[i] <= '0;
            end
        end else if (o_take) begin
            if (p_ext <= CMP_W'(MAX_FRAME)) begin
                r_pos <= r_pos + POS_W'(1);
            end
            r_hdr_good <= n_hdr_good;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_rx_crc   <= n_rx_crc;
            r_crc_seen <= n_crc_seen;
            r_last_cr  <= (i_byte == CR_BYTE);
            r_field    <= n_field;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos) <= CMP_W'(MAX_FRAME + 1))
        else $error("byte position beyond saturation point");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0) && r_hdr_good && !r_crc_seen)
        else $error("frame state not cleared after frame end");

    a_hdr_bad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hdr_good |-> (r_pos != '0))
        else $error("header error flagged before any byte");

    a_ok_needs_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OK) |-> n_crc_seen)
        else $error("ok status without a received crc byte");

endmodule

// ----- sv/crc8fp_out_reg.sv -----
// result register between the frame logic and the output channel
module crc8fp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  crc8fp_pkg::t_result i_res,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output crc8fp_pkg::t_result o_res
);
    import crc8fp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- sv/crc8_checked_frame_parser_top.sv -----
// top level of the crc8 checked frame parser
// input channel: one received byte per transfer on i_rx_byte (i_valid, o_stall)
// frames open with 0x55 0xaa, a length byte, payload and a crc-8 byte (poly 0x8c
// reflected, init 0) and close at the first cr directly followed by lf
// output channel: one result per closed frame (o_valid, i_stall) carrying
// o_status and four little-endian signed words from frame bytes 3 to 18,
// zero unless status is ok
// throughput: one byte per cycle while o_stall is low, with the byte-wide crc
// update and field capture combinational between input and result registers
// a closing lf passes through the input register and then the result register,
// and o_valid rises when the result register loads the result of its frame
// bytes that do not close a frame keep flowing while a result waits; a closing
// lf is held in the input register, with o_stall high, until the receiver takes
// the pending result and the result register is free
// reset (i_rst_n low, synchronous) empties both registers and clears the frame
// state, so the next byte is taken as frame position zero
module crc8_checked_frame_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_yaw_milli,
    output logic signed [31:0] o_left_wheel,
    output logic signed [31:0] o_right_wheel,
    output logic signed [31:0] o_flag_word
);
    import crc8fp_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    crc8fp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_take    (take),
        .o_stall   (o_stall),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    crc8fp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crc8fp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_status      = out_res.status;
    assign o_yaw_milli   = out_res.yaw_milli;
    assign o_left_wheel  = out_res.left_wheel;
    assign o_right_wheel = out_res.right_wheel;
    assign o_flag_word   = out_res.flag_word;

endmodule
